>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by the date adder core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next cycle check failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// types and constants for the gregorian date adder
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned OffW   = 17;
  localparam int unsigned DaccW  = 18;
  localparam int unsigned YaccW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [YearW-1:0] MinYearRst = 14'd1902;
  localparam logic [YearW-1:0] MaxYearRst = 14'd2037;
  localparam logic [YearW-1:0] QuadCent   = 14'd400;
  localparam logic [YearW-1:0] QuadCentM1 = 14'd399;

  localparam logic [MonW-1:0] MonJan = 4'd1;
  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonDec = 4'd12;

  localparam logic [CfgIdxW-1:0] CFG_MIN_YEAR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_YEAR = 2'd1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_INVALID = 2'd2
  } gda_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_FWD,
    ST_BWD,
    ST_FINAL,
    ST_DONE
  } gda_state_t;

  typedef struct packed {
    logic [DayW-1:0]         day;
    logic [MonW-1:0]         month;
    logic [YearW-1:0]        year;
    logic signed [OffW-1:0]  offset_days;
  } gda_item_t;

  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
    gda_status_t      status;
  } gda_result_t;

endpackage

>>> hw/rtl/gda_mlen.sv
// ----------------------------------------------------------------------------
// gda_mlen
// month length unit, leap rule taken from the year modulo 400
// ----------------------------------------------------------------------------
module gda_mlen import gda_pkg::*; (
  input  logic [MonW-1:0]  month,
  input  logic [YearW-1:0] yr_mod,
  output logic [DayW-1:0]  len
);

  logic leap;

  always_comb begin
    leap = (yr_mod[1:0] == 2'b00) &&
           ((yr_mod == 14'd0) ||
            !((yr_mod == 14'd100) || (yr_mod == 14'd200) || (yr_mod == 14'd300)));
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MonFeb:                  len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
  end

endmodule

>>> hw/rtl/gda_core.sv
// ----------------------------------------------------------------------------
// gda_core
// sequencer walking the date one month per cycle through one shared adder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gda_core import gda_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gda_item_t         item,
  input  logic [YearW-1:0]  min_year,
  input  logic [YearW-1:0]  max_year,
  output logic              busy,
  output logic              res_valid,
  input  logic              res_take,
  output gda_result_t       res
);

  gda_state_t state_r, state_nxt;

  logic signed [DaccW-1:0] d_r, d_nxt;
  logic [MonW-1:0]         m_r, m_nxt;
  logic signed [YaccW-1:0] y_r, y_nxt;
  logic [YearW-1:0]        c_r, c_nxt;
  logic signed [OffW-1:0]  off_r, off_nxt;
  gda_item_t               in_r, in_nxt;
  gda_status_t             stat_r, stat_nxt;

  logic [MonW-1:0]         m_s, m_p, mlen_m;
  logic signed [YaccW-1:0] y_s, y_p;
  logic [YearW-1:0]        c_s, c_p, mlen_c;
  logic [DayW-1:0]         len;
  logic signed [DaccW-1:0] len_x, add_b, sum;
  logic signed [YaccW-1:0] ymin_x, ymax_x;
  logic                    in_ok;

  gda_mlen u_mlen (
    .month  (mlen_m),
    .yr_mod (mlen_c),
    .len    (len)
  );

  always_comb begin
    m_s = (m_r == MonDec) ? MonJan : m_r + 4'd1;
    y_s = (m_r == MonDec) ? y_r + 16'sd1 : y_r;
    c_s = (m_r == MonDec) ? ((c_r == QuadCentM1) ? 14'd0 : c_r + 14'd1) : c_r;
    m_p = (m_r == MonJan) ? MonDec : m_r - 4'd1;
    y_p = (m_r == MonJan) ? y_r - 16'sd1 : y_r;
    c_p = (m_r == MonJan) ? ((c_r == 14'd0) ? QuadCentM1 : c_r - 14'd1) : c_r;
  end

  // shared month length lookup and day adder
  always_comb begin
    mlen_m = (state_r == ST_BWD) ? m_p : m_r;
    mlen_c = (state_r == ST_BWD) ? c_p : c_r;
    len_x  = $signed({13'd0, len});
    case (state_r)
      ST_CHECK: add_b = {off_r[OffW-1], off_r};
      ST_FWD:   add_b = -len_x;
      default:  add_b = len_x;
    endcase
    sum    = d_r + add_b;
    ymin_x = $signed({2'b00, min_year});
    ymax_x = $signed({2'b00, max_year});
    in_ok  = (in_r.year >= min_year) && (in_r.year <= max_year) &&
             (in_r.month >= MonJan) && (in_r.month <= MonDec) &&
             (in_r.day != 5'd0) && (in_r.day <= len);
  end

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    m_nxt     = m_r;
    y_nxt     = y_r;
    c_nxt     = c_r;
    off_nxt   = off_r;
    in_nxt    = in_r;
    stat_nxt  = stat_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_nxt    = item;
          d_nxt     = $signed({13'd0, item.day});
          m_nxt     = item.month;
          y_nxt     = $signed({2'b00, item.year});
          c_nxt     = item.year;
          off_nxt   = item.offset_days;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (c_r >= QuadCent) begin
          c_nxt = c_r - QuadCent;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!in_ok) begin
          stat_nxt  = STAT_INVALID;
          state_nxt = ST_DONE;
        end else begin
          d_nxt     = sum;
          state_nxt = ST_FWD;
        end
      end
      ST_FWD: begin
        if (d_r > len_x) begin
          d_nxt = sum;
          m_nxt = m_s;
          y_nxt = y_s;
          c_nxt = c_s;
        end else begin
          state_nxt = ST_BWD;
        end
      end
      ST_BWD: begin
        if (d_r < 18'sd1) begin
          d_nxt = sum;
          m_nxt = m_p;
          y_nxt = y_p;
          c_nxt = c_p;
        end else begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        stat_nxt  = ((y_r >= ymin_x) && (y_r <= ymax_x)) ? STAT_OK : STAT_RANGE;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    m_r    <= m_nxt;
    y_r    <= y_nxt;
    c_r    <= c_nxt;
    off_r  <= off_nxt;
    in_r   <= in_nxt;
    stat_r <= stat_nxt;
  end

  always_comb begin
    busy       = (state_r != ST_IDLE);
    res_valid  = (state_r == ST_DONE);
    res.status = stat_r;
    if (stat_r == STAT_OK) begin
      res.day   = d_r[DayW-1:0];
      res.month = m_r;
      res.year  = y_r[YearW-1:0];
    end else begin
      res.day   = in_r.day;
      res.month = in_r.month;
      res.year  = in_r.year;
    end
  end

  `ASSERT_IMP(a_walk_month, clk, rst_n, (state_r == ST_FWD || state_r == ST_BWD), (m_r >= MonJan && m_r <= MonDec))
  `ASSERT_IMP(a_walk_mod, clk, rst_n, (state_r == ST_FWD || state_r == ST_BWD), (c_r < QuadCent))
  `ASSERT_IMP(a_ok_day, clk, rst_n, (state_r == ST_DONE && stat_r == STAT_OK), (d_r >= 18'sd1 && d_r <= 18'sd31))
  `ASSERT_NXT(a_start, clk, rst_n, (state_r == ST_IDLE && start), (state_r == ST_MOD))

endmodule

>>> hw/rtl/gregorian_date_add_days.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// gregorian date plus signed day offset, walked one month per cycle
// steps: year modulo 400, input check, forward then backward month walk, year range check; invalid input skips the walk
// a new input beat is accepted only while the core is idle; in_stall is held high meanwhile
// a finished result may wait in the output register while the next beat enters
// synchronous active-low reset: idle, no output beat, years back to 1902..2037
// ----------------------------------------------------------------------------
module gregorian_date_add_days import gda_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DayW-1:0]      in_day,
  input  logic [MonW-1:0]      in_month,
  input  logic [YearW-1:0]     in_year,
  input  logic signed [OffW-1:0] in_offset_days,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DayW-1:0]      out_new_day,
  output logic [MonW-1:0]      out_new_month,
  output logic [YearW-1:0]     out_new_year,
  output logic [1:0]           out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [YearW-1:0]     cfg_data
);

  logic [YearW-1:0] min_year_r, max_year_r;
  logic             out_valid_r, out_valid_nxt;
  gda_result_t      out_r;
  gda_item_t        item;
  gda_result_t      res;
  logic             busy, res_valid, res_take, start;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MinYearRst;
      max_year_r <= MaxYearRst;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MIN_YEAR) begin
        min_year_r <= cfg_data;
      end else if (cfg_index == CFG_MAX_YEAR) begin
        max_year_r <= cfg_data;
      end
    end
  end

  always_comb begin
    item.day         = in_day;
    item.month       = in_month;
    item.year        = in_year;
    item.offset_days = in_offset_days;
    in_stall         = busy;
    start            = in_valid && !busy;
    res_take         = !out_valid_r || !out_stall;
    out_valid_nxt    = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  gda_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .min_year  (min_year_r),
    .max_year  (max_year_r),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_day   = out_r.day;
  assign out_new_month = out_r.month;
  assign out_new_year  = out_r.year;
  assign out_status    = out_r.status;

endmodule
